[hw/rtl/dip_pkg.sv]
package dip_pkg;

    // Parse phases
    localparam logic [2:0] PH_LEAD  = 3'd0;
    localparam logic [2:0] PH_ZERO  = 3'd1;
    localparam logic [2:0] PH_DIG   = 3'd2;
    localparam logic [2:0] PH_TRAIL = 3'd3;
    localparam logic [2:0] PH_DONE  = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOT_INT  = 2'd1;
    localparam logic [1:0] ST_GARBAGE  = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    localparam int unsigned MAG_W = 34;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;

    localparam logic [3:0] MAX_SIG_DIGITS = 4'd10;

    localparam logic [MAG_W-1:0] POS_LIMIT = 34'd2147483647;
    localparam logic [MAG_W-1:0] NEG_LIMIT = 34'd2147483648;

    // Parser state carried between characters of one string
    typedef struct packed {
        logic [2:0]       phase;
        logic             is_negative;
        logic             saw_zero;
        logic [MAG_W-1:0] magnitude;
        logic [3:0]       sig_count;
        logic             not_int_flag;
        logic             garbage_flag;
    } dip_state_t;

    localparam dip_state_t STATE_RESET = '{
        phase:        PH_LEAD,
        is_negative:  1'b0,
        saw_zero:     1'b0,
        magnitude:    '0,
        sig_count:    4'd0,
        not_int_flag: 1'b0,
        garbage_flag: 1'b0
    };

    function automatic logic is_ws(input logic [7:0] c);
        return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

[hw/rtl/dip_if.sv]
interface dip_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;

    modport source (output valid, output character, input ready);
    modport sink (input valid, input character, output ready);
endinterface

interface dip_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic [1:0]         status;

    modport source (output valid, output value, output status, input ready);
    modport sink (input valid, input value, input status, output ready);
endinterface

[hw/rtl/dip_step.sv]
module dip_step (
    input  dip_pkg::dip_state_t state,
    input  logic [7:0]          character,
    output dip_pkg::dip_state_t state_next,
    output logic signed [31:0]  value,
    output logic [1:0]          status
);
    import dip_pkg::*;

    logic [MAG_W-1:0] mag_times_ten;
    logic [MAG_W-1:0] mag_digit;
    dip_state_t       with_digit;
    logic             final_not_int;
    logic [MAG_W-1:0] limit;
    logic [31:0]      mag_low;

    // Multiply by ten as two shifts and an add, then add the digit
    always_comb
    begin
        mag_times_ten = (state.magnitude << 3) + (state.magnitude << 1);
        mag_digit     = mag_times_ten + {{(MAG_W-8){1'b0}}, character - CH_ZERO};
    end

    // Fold one significant digit into the state
    always_comb
    begin
        with_digit = state;
        if (state.sig_count < MAX_SIG_DIGITS)
        begin
            with_digit.magnitude = mag_digit;
        end
        if (state.sig_count <= MAX_SIG_DIGITS)
        begin
            with_digit.sig_count = state.sig_count + 4'd1;
        end
        with_digit.phase = PH_DIG;
    end

    // Result on end of string
    always_comb
    begin
        final_not_int = state.not_int_flag ||
                        (((state.phase == PH_LEAD) || (state.phase == PH_ZERO)) &&
                         !state.saw_zero);
        limit   = state.is_negative ? NEG_LIMIT : POS_LIMIT;
        mag_low = state.magnitude[31:0];
        value   = '0;
        priority if (final_not_int)
        begin
            status = ST_NOT_INT;
        end
        else if (state.garbage_flag)
        begin
            status = ST_GARBAGE;
        end
        else if ((state.sig_count > MAX_SIG_DIGITS) || (state.magnitude > limit))
        begin
            status = ST_OVERFLOW;
        end
        else
        begin
            status = ST_OK;
            value  = state.is_negative ? $signed(32'd0 - mag_low) : $signed(mag_low);
        end
    end

    // Advance the parse by one character
    always_comb
    begin
        state_next = state;
        if (character == CH_NUL)
        begin
            state_next = STATE_RESET;
        end
        else
        begin
            unique case (state.phase)
                PH_LEAD, PH_ZERO:
                begin
                    priority if ((state.phase == PH_LEAD) && is_ws(character))
                    begin
                        state_next = state;
                    end
                    else if ((state.phase == PH_LEAD) && (character == CH_MINUS))
                    begin
                        state_next.is_negative = 1'b1;
                        state_next.phase       = PH_ZERO;
                    end
                    else if (character == CH_ZERO)
                    begin
                        state_next.saw_zero = 1'b1;
                        state_next.phase    = PH_ZERO;
                    end
                    else if (is_dig(character))
                    begin
                        state_next = with_digit;
                    end
                    else if (!state.saw_zero)
                    begin
                        state_next.not_int_flag = 1'b1;
                        state_next.phase        = PH_DONE;
                    end
                    else if (is_ws(character))
                    begin
                        state_next.phase = PH_TRAIL;
                    end
                    else
                    begin
                        state_next.garbage_flag = 1'b1;
                        state_next.phase        = PH_DONE;
                    end
                end
                PH_DIG:
                begin
                    priority if (is_dig(character))
                    begin
                        state_next = with_digit;
                    end
                    else if (is_ws(character))
                    begin
                        state_next.phase = PH_TRAIL;
                    end
                    else
                    begin
                        state_next.garbage_flag = 1'b1;
                        state_next.phase        = PH_DONE;
                    end
                end
                PH_TRAIL:
                begin
                    if (!is_ws(character))
                    begin
                        state_next.garbage_flag = 1'b1;
                        state_next.phase        = PH_DONE;
                    end
                end
                default:
                begin
                    state_next.phase = PH_DONE;
                end
            endcase
        end
    end

endmodule

[hw/rtl/decimal_int_parser_core.sv]
// Strict signed 32-bit decimal parser. Send a string one byte per transaction,
// ending with NUL (0); the NUL yields one result transaction carrying the
// value and a status (0 ok, 1 not an int, 2 trailing garbage, 3 overflow),
// with value 0 whenever the status is not ok. Every other byte yields
// nothing. One byte is taken every cycle while the input does not stall; a
// result is offered from the result register after its NUL passes the input
// register and then the parse step. Input stalls only when a NUL is waiting
// and the result register still holds a result that is not being taken in
// that cycle.
module decimal_int_parser_core (
    input  logic clk,
    input  logic rst_n,
    dip_char_if.sink     chars,
    dip_result_if.source results
);
    import dip_pkg::*;

    logic               in_valid_reg;
    logic [7:0]         char_reg;
    dip_state_t         state_reg;
    dip_state_t         state_next;
    logic               out_valid_reg;
    logic signed [31:0] value_reg;
    logic [1:0]         status_reg;
    logic signed [31:0] step_value;
    logic [1:0]         step_status;
    logic               is_nul;
    logic               stall;
    logic               process;

    dip_step u_step (
        .state      (state_reg),
        .character  (char_reg),
        .state_next (state_next),
        .value      (step_value),
        .status     (step_status)
    );

    // Hold a NUL while the result register is occupied and not being taken
    assign is_nul       = (char_reg == CH_NUL);
    assign stall        = in_valid_reg && is_nul && out_valid_reg && !results.ready;
    assign process      = in_valid_reg && !stall;
    assign chars.ready  = !stall;

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!stall)
        begin
            in_valid_reg <= chars.valid;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            char_reg <= chars.character;
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (process)
        begin
            state_reg <= state_next;
        end
    end

    // Result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (process && is_nul)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (process && is_nul)
        begin
            value_reg  <= step_value;
            status_reg <= step_status;
        end
    end

    assign results.valid  = out_valid_reg;
    assign results.value  = value_reg;
    assign results.status = status_reg;

endmodule
